>>> hw/rtl/sclr_pkg.sv
// Types, constants and character tables shared by the command line recognizer.
`timescale 1ns / 1ps

package sclr_pkg;

    localparam int NUM_KEYS = 6;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_H     = 8'h48;

    localparam logic [2:0] CODE_OK      = 3'd0;
    localparam logic [2:0] CODE_VITALS  = 3'd1;
    localparam logic [2:0] CODE_HELP    = 3'd2;
    localparam logic [2:0] CODE_RANGE   = 3'd3;
    localparam logic [2:0] CODE_UNKNOWN = 3'd4;
    localparam logic [2:0] CODE_LONG    = 3'd5;

    // Keyword order sets the match priority: STATUS, VITALS?, ACK, SILENCE, HELP, SET.
    localparam logic [7:0] KEY_TEXT [NUM_KEYS][8] = '{
        '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
        '{"V", "I", "T", "A", "L", "S", "?", 8'h00},
        '{"A", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "I", "L", "E", "N", "C", "E", 8'h00},
        '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [5:0] KEY_LEN [NUM_KEYS] = '{6'd6, 6'd7, 6'd3, 6'd7, 6'd4, 6'd3};

    localparam logic [2:0] HRLOW_LEN = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } result_t;

    function automatic logic [7:0] hrlow_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "H";
            3'd1:    ch = "R";
            3'd2:    ch = "L";
            3'd3:    ch = "O";
            3'd4:    ch = "W";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/sclr_matcher.sv
// Per-line state and single-pass keyword matching for each received byte.
`timescale 1ns / 1ps

module sclr_matcher #(
    parameter int MAX_LINE = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    output sclr_pkg::result_t     result
);

    logic [5:0] char_count_reg, char_count_next;
    logic       too_long_reg, too_long_next;
    logic       text_started_reg, text_started_next;
    logic [5:0] text_position_reg, text_position_next;
    logic [sclr_pkg::NUM_KEYS-1:0] keyword_alive_reg, keyword_alive_next;
    logic       text_ended_reg, text_ended_next;
    logic [2:0] substring_progress_reg, substring_progress_next;
    logic       substring_found_reg, substring_found_next;

    logic [sclr_pkg::NUM_KEYS-1:0] key_hit;
    logic [2:0] line_code;
    logic       is_eol;

    always_comb begin
        for (int k = 0; k < sclr_pkg::NUM_KEYS; k++) begin
            key_hit[k] = keyword_alive_reg[k] && (text_position_reg >= sclr_pkg::KEY_LEN[k]);
        end
        if (key_hit[0]) begin
            line_code = sclr_pkg::CODE_OK;
        end else if (key_hit[1]) begin
            line_code = sclr_pkg::CODE_VITALS;
        end else if (key_hit[2] || key_hit[3]) begin
            line_code = sclr_pkg::CODE_OK;
        end else if (key_hit[4]) begin
            line_code = sclr_pkg::CODE_HELP;
        end else if (key_hit[5]) begin
            line_code = substring_found_reg ? sclr_pkg::CODE_OK : sclr_pkg::CODE_RANGE;
        end else begin
            line_code = sclr_pkg::CODE_UNKNOWN;
        end
    end

    assign is_eol = (rx_byte == sclr_pkg::CHAR_CR) || (rx_byte == sclr_pkg::CHAR_LF);

    always_comb begin
        char_count_next         = char_count_reg;
        too_long_next           = too_long_reg;
        text_started_next       = text_started_reg;
        text_position_next      = text_position_reg;
        keyword_alive_next      = keyword_alive_reg;
        text_ended_next         = text_ended_reg;
        substring_progress_next = substring_progress_reg;
        substring_found_next    = substring_found_reg;
        result                  = '0;

        if (accept) begin
            if (is_eol) begin
                if (too_long_reg) begin
                    result.valid = 1'b1;
                    result.code  = sclr_pkg::CODE_LONG;
                end else if (text_started_reg) begin
                    result.valid = 1'b1;
                    result.code  = line_code;
                end
                char_count_next         = '0;
                too_long_next           = 1'b0;
                text_started_next       = 1'b0;
                text_position_next      = '0;
                keyword_alive_next      = '1;
                text_ended_next         = 1'b0;
                substring_progress_next = '0;
                substring_found_next    = 1'b0;
            end else if (!too_long_reg) begin
                if (char_count_reg < 6'(MAX_LINE)) begin
                    char_count_next = char_count_reg + 6'd1;
                    // Matching stops at a zero byte; leading spaces are skipped.
                    if (!text_ended_reg) begin
                        if (rx_byte == sclr_pkg::CHAR_NUL) begin
                            text_ended_next = 1'b1;
                        end else if (text_started_reg || rx_byte != sclr_pkg::CHAR_SPACE) begin
                            text_started_next = 1'b1;
                            for (int k = 0; k < sclr_pkg::NUM_KEYS; k++) begin
                                if (text_position_reg < sclr_pkg::KEY_LEN[k] &&
                                    rx_byte != sclr_pkg::KEY_TEXT[k][text_position_reg[2:0]]) begin
                                    keyword_alive_next[k] = 1'b0;
                                end
                            end
                            // HRLOW has no repeated letter, so a mismatch restarts at H.
                            if (rx_byte == sclr_pkg::hrlow_char(substring_progress_reg)) begin
                                if (substring_progress_reg == sclr_pkg::HRLOW_LEN - 3'd1) begin
                                    substring_found_next    = 1'b1;
                                    substring_progress_next = '0;
                                end else begin
                                    substring_progress_next = substring_progress_reg + 3'd1;
                                end
                            end else begin
                                substring_progress_next =
                                    (rx_byte == sclr_pkg::CHAR_H) ? 3'd1 : 3'd0;
                            end
                            if (text_position_reg != 6'h3F) begin
                                text_position_next = text_position_reg + 6'd1;
                            end
                        end
                    end
                end else begin
                    too_long_next   = 1'b1;
                    char_count_next = '0;
                    result.valid    = 1'b1;
                    result.code     = sclr_pkg::CODE_LONG;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg         <= '0;
            too_long_reg           <= 1'b0;
            text_started_reg       <= 1'b0;
            text_position_reg      <= '0;
            keyword_alive_reg      <= '1;
            text_ended_reg         <= 1'b0;
            substring_progress_reg <= '0;
            substring_found_reg    <= 1'b0;
        end else begin
            char_count_reg         <= char_count_next;
            too_long_reg           <= too_long_next;
            text_started_reg       <= text_started_next;
            text_position_reg      <= text_position_next;
            keyword_alive_reg      <= keyword_alive_next;
            text_ended_reg         <= text_ended_next;
            substring_progress_reg <= substring_progress_next;
            substring_found_reg    <= substring_found_next;
        end
    end

endmodule

>>> hw/rtl/serial_command_line_recognizer.sv
// Top level of the serial command line recognizer: handshake and result register.
`timescale 1ns / 1ps

// Takes one received byte per transfer and answers each command line ended by CR or LF
// with one reply code (0 ok, 1 vitals list, 2 help list, 3 range error,
// 4 unknown command, 5 line too long); a blank line gets no reply, and a line that
// grows past MAX_LINE bytes gets code 5 at once and again at its end. The line state
// is updated in the cycle of the transfer and the reply lands in a single result
// register, so a byte is taken every cycle as long as that register is empty or
// being read in the same cycle.

module serial_command_line_recognizer #(
    parameter int MAX_LINE = 40
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_reply_code
);

    sclr_pkg::result_t result;
    logic       accept;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_reply_code_reg, m_reply_code_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sclr_matcher #(
        .MAX_LINE (MAX_LINE)
    ) u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    always_comb begin
        m_valid_next      = m_valid_reg;
        m_reply_code_next = m_reply_code_reg;
        if (accept) begin
            m_valid_next = result.valid;
            if (result.valid) begin
                m_reply_code_next = result.code;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reply_code_reg <= m_reply_code_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reply_code = m_reply_code_reg;

endmodule

>>> hw/rtl/sclr_checker.sv
// Port-level assertions for the command line recognizer and their bind.
`timescale 1ns / 1ps

module sclr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_reply_code
);

    // A reset cycle leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // An empty result register must never hold off the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // A waiting result must not be overwritten by a new transfer.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_reply_code)))
        else $error("stalled result changed");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reply_code <= sclr_pkg::CODE_LONG))
        else $error("reply code out of range");

endmodule

bind serial_command_line_recognizer sclr_checker u_sclr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_reply_code (m_reply_code)
);
